FILE: sv/bmhq_pkg.sv
package bmhq_pkg;

  // default sizes
  localparam int HEAP_DEPTH_DEF = 64;
  localparam int KEY_BITS_DEF   = 16;
  localparam int TAG_BITS_DEF   = 8;

  // operation codes carried on in_tuser
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

endpackage

FILE: sv/bmhq_ram.sv
module bmhq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: sv/binary_max_heap_queue.sv
// Binary max-heap priority queue of up to HEAP_DEPTH entries, each an unsigned
// key and a payload tag, kept in a RAM with two read ports and one write port.
// An insert (in_tuser = 0) appends the entry and sifts it up past strictly
// smaller parents; a remove (in_tuser = 1) takes the root, moves the last entry
// there and sifts it down, the left child winning a tie. Each transaction gives
// one result: status, the root entry after the operation and the entry count.
// An insert and a remove each run a RAM read and compare loop that handles one
// tree level per cycle; the finished result then waits until the result
// register is free. One operation is in flight at a time; a new transaction
// is taken while the previous result waits.
module binary_max_heap_queue #(
  parameter int HEAP_DEPTH = bmhq_pkg::HEAP_DEPTH_DEF,
  parameter int KEY_BITS   = bmhq_pkg::KEY_BITS_DEF,
  parameter int TAG_BITS   = bmhq_pkg::TAG_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // input channel
  input  logic in_tvalid,
  output logic in_tready,
  input  logic in_tuser,   // kind
  input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0] in_tdata,  // key, tag
  // result channel
  output logic out_tvalid,
  input  logic out_tready,
  // status, top_valid, top_key, top_tag, entry_count
  output logic [((3+KEY_BITS+TAG_BITS+$clog2(HEAP_DEPTH+1)+7)/8)*8-1:0] out_tdata
);

  localparam int IDX_W  = $clog2(HEAP_DEPTH);
  localparam int CNT_W  = $clog2(HEAP_DEPTH+1);
  localparam int CH_W   = IDX_W + 2;
  localparam int ENT_W  = KEY_BITS + TAG_BITS;
  localparam int OFLD_W = 3 + ENT_W + CNT_W;
  localparam int OUT_W  = ((OFLD_W + 7) / 8) * 8;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DOWN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic [ENT_W-1:0]  ent_r, ent_nxt;
  logic [ENT_W-1:0]  root_r;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OFLD_W-1:0] out_data_r, out_data_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [IDX_W-1:0]  rd_addr_a, rd_addr_b;
  logic [ENT_W-1:0]  rd_data_a, rd_data_b;

  logic              in_acc;
  logic [KEY_BITS-1:0] in_key;
  logic [TAG_BITS-1:0] in_tag;
  logic              heap_full, heap_empty;
  logic [CNT_W-1:0]  fill_dec;
  logic [IDX_W-1:0]  pos_m1, up_par, up_par_m1;
  logic [KEY_BITS-1:0] ent_key, key_a, key_b, big_key;
  logic [CH_W-1:0]   lc_w, rc_w, n_w, best_w, nl_w, nr_w;
  logic              pick_l, pick_r;
  logic [IDX_W-1:0]  best_idx;
  logic [ENT_W-1:0]  best_ent;
  logic              fin_load;

  bmhq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (rd_data_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (rd_data_b)
  );

  // input unpacking and heap bookkeeping
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_key     = in_tdata[KEY_BITS-1:0];
  assign in_tag     = in_tdata[ENT_W-1:KEY_BITS];
  assign heap_full  = (fill_r == CNT_W'(HEAP_DEPTH));
  assign heap_empty = (fill_r == '0);
  assign fill_dec   = fill_r - CNT_W'(1);

  // sift-up parent addresses
  assign pos_m1    = pos_r - IDX_W'(1);
  assign up_par    = pos_m1 >> 1;
  assign up_par_m1 = (up_par - IDX_W'(1)) >> 1;

  // sift-down child selection, strict compare so the left child wins a tie
  assign ent_key  = ent_r[KEY_BITS-1:0];
  assign key_a    = rd_data_a[KEY_BITS-1:0];
  assign key_b    = rd_data_b[KEY_BITS-1:0];
  assign lc_w     = {1'b0, pos_r, 1'b1};
  assign rc_w     = lc_w + CH_W'(1);
  assign n_w      = CH_W'(fill_r);
  assign pick_l   = (lc_w < n_w) && (key_a > ent_key);
  assign big_key  = pick_l ? key_a : ent_key;
  assign pick_r   = (rc_w < n_w) && (key_b > big_key);
  assign best_w   = pick_r ? rc_w : lc_w;
  assign best_ent = pick_r ? rd_data_b : rd_data_a;
  assign best_idx = best_w[IDX_W-1:0];
  assign nl_w     = {1'b0, best_idx, 1'b1};
  assign nr_w     = nl_w + CH_W'(1);

  assign fin_load = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // operation sequencer
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    pos_nxt    = pos_r;
    ent_nxt    = ent_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = ent_r;
    rd_addr_a  = '0;
    rd_addr_b  = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = bmhq_pkg::STAT_DONE;
          if (in_tuser == bmhq_pkg::KIND_INSERT) begin
            if (heap_full) begin
              status_nxt = bmhq_pkg::STAT_FULL;
              state_nxt  = S_FIN;
            end else begin
              fill_nxt  = fill_r + CNT_W'(1);
              ent_nxt   = {in_tag, in_key};
              pos_nxt   = fill_r[IDX_W-1:0];
              rd_addr_a = IDX_W'(fill_dec >> 1);
              state_nxt = S_UP;
            end
          end else begin
            if (heap_empty) begin
              status_nxt = bmhq_pkg::STAT_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              fill_nxt  = fill_dec;
              rd_addr_a = fill_dec[IDX_W-1:0];
              state_nxt = (fill_dec == '0) ? S_FIN : S_LOAD;
            end
          end
        end
      end
      S_UP: begin
        wr_en = 1'b1;
        if (pos_r == '0) begin
          state_nxt = S_FIN;
        end else if (key_a < ent_key) begin
          // parent moves down into the hole
          wr_data   = rd_data_a;
          pos_nxt   = up_par;
          rd_addr_a = up_par_m1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_LOAD: begin
        ent_nxt   = rd_data_a;
        pos_nxt   = '0;
        rd_addr_a = IDX_W'(1);
        rd_addr_b = IDX_W'(2);
        state_nxt = S_DOWN;
      end
      S_DOWN: begin
        wr_en = 1'b1;
        if (pick_l || pick_r) begin
          // larger child moves up into the hole
          wr_data   = best_ent;
          pos_nxt   = best_idx;
          rd_addr_a = nl_w[IDX_W-1:0];
          rd_addr_b = nr_w[IDX_W-1:0];
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (fin_load) begin
      out_valid_nxt = 1'b1;
      if (heap_empty) begin
        out_data_nxt = {fill_r, {ENT_W{1'b0}}, 1'b0, status_r};
      end else begin
        out_data_nxt = {fill_r, root_r, 1'b1, status_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload state, root copy tracks every write to the root entry
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    ent_r      <= ent_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    if (wr_en && (wr_addr == '0)) begin
      root_r <= wr_data;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(HEAP_DEPTH))
    else $error("heap count above depth");

  a_up_hole: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP) |-> (CNT_W'(pos_r) < fill_r))
    else $error("sift-up hole outside heap");

  a_down_hole: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DOWN) |-> (CNT_W'(pos_r) < fill_r))
    else $error("sift-down hole outside heap");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == bmhq_pkg::KIND_INSERT) && !heap_full)
      |=> (fill_r == $past(fill_r) + CNT_W'(1)))
    else $error("insert did not grow heap");

endmodule
